/* rtl/core/ppdc_pkg.sv */
// Package for the positional PID block with dead band and clamps.
// Holds register indexes, field widths and the configuration struct.
// No dependencies.
package ppdc_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_ADDR_W-1:0] REG_KP           = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_KI           = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_KD           = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_DEAD_BAND    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_INTEGRAL_MAX = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_I_TERM_MAX   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_OUTPUT_MAX   = 3'd6;

   localparam int DATA_W = 16;
   localparam int ERR_W  = 17;
   localparam int SUM_W  = 18;
   localparam int DIFF_W = 18;
   localparam int TERM_W = 29;

   localparam logic [14:0] OUTPUT_MAX_RST = 15'h7FFF;

   typedef struct packed {
      logic [15:0] kp;
      logic [15:0] ki;
      logic [15:0] kd;
      logic [15:0] dead_band;
      logic [16:0] integral_max;
      logic [14:0] i_term_max;
      logic [14:0] output_max;
   } cfg_type;

endpackage

/* rtl/core/positional_pid_deadband_clamp.sv */
// Positional PID controller with error dead band, integral clamp, I-term clamp
// and output saturation. Takes one setpoint/measured transfer per cycle while
// the result side does not stall and returns one drive transfer per input,
// passing the input register, error stage (dead band and error-sum update, a
// feedback loop) and result register. The three gain products run in
// parallel in the last stage. Gains and limits come from a write-only register
// port, to be written by the user only while the block is idle; not enforced.
// Depends on ppdc_pkg and ppdc_terms.
module positional_pid_deadband_clamp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [ppdc_pkg::DATA_W-1:0]    req_setpoint,
   input  logic signed [ppdc_pkg::DATA_W-1:0]    req_measured,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [ppdc_pkg::DATA_W-1:0]    rsp_drive,
   input  logic                                  csr_we,
   input  logic [ppdc_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [ppdc_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import ppdc_pkg::*;

   cfg_type                   cfg_ff;
   cfg_type                   cfg_in;

   logic                      s1_valid_ff;
   logic signed [DATA_W-1:0]  s1_setpoint_ff;
   logic signed [DATA_W-1:0]  s1_measured_ff;

   logic                      s2_valid_ff;
   logic signed [ERR_W-1:0]   s2_err_ff;
   logic signed [SUM_W-1:0]   s2_sum_ff;
   logic signed [DIFF_W-1:0]  s2_diff_ff;

   logic                      rsp_valid_ff;
   logic signed [DATA_W-1:0]  rsp_drive_ff;

   logic signed [SUM_W-1:0]   error_sum_ff;
   logic signed [SUM_W-1:0]   error_sum_in;
   logic signed [ERR_W-1:0]   prev_err_ff;

   logic                      out_load;
   logic                      s2_load;
   logic                      s1_load;
   logic                      s1_move;

   logic signed [ERR_W-1:0]   err_raw;
   logic signed [ERR_W-1:0]   err;
   logic signed [SUM_W-1:0]   err_wide;
   logic signed [SUM_W-1:0]   db_lim;
   logic signed [SUM_W:0]     sum_raw;
   logic signed [SUM_W:0]     sum_lim;
   logic signed [SUM_W:0]     sum_sat;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [DATA_W-1:0]  drive;

   // config writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_KP:           cfg_in.kp           = csr_wdata[15:0];
            REG_KI:           cfg_in.ki           = csr_wdata[15:0];
            REG_KD:           cfg_in.kd           = csr_wdata[15:0];
            REG_DEAD_BAND:    cfg_in.dead_band    = csr_wdata[15:0];
            REG_INTEGRAL_MAX: cfg_in.integral_max = csr_wdata[16:0];
            REG_I_TERM_MAX:   cfg_in.i_term_max   = csr_wdata[14:0];
            REG_OUTPUT_MAX:   cfg_in.output_max   = csr_wdata[14:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{kp: 16'd0, ki: 16'd0, kd: 16'd0, dead_band: 16'd0,
                    integral_max: 17'd0, i_term_max: 15'd0,
                    output_max: OUTPUT_MAX_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stage flow control
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign s2_load   = !s2_valid_ff || out_load;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign s1_move   = s1_valid_ff && s2_load;
   assign req_ready = s1_load;

   // error, dead band and error-sum update
   always_comb begin
      err_raw  = signed'({s1_setpoint_ff[DATA_W-1], s1_setpoint_ff})
               - signed'({s1_measured_ff[DATA_W-1], s1_measured_ff});
      err_wide = signed'({err_raw[ERR_W-1], err_raw});
      db_lim   = signed'({2'b00, cfg_ff.dead_band});
      if (err_wide > -db_lim && err_wide < db_lim) begin
         err = '0;
      end else begin
         err = err_raw;
      end

      sum_raw = signed'({error_sum_ff[SUM_W-1], error_sum_ff})
              + signed'({{2{err[ERR_W-1]}}, err});
      sum_lim = signed'({2'b00, cfg_ff.integral_max});
      if (sum_raw > sum_lim) begin
         sum_sat = sum_lim;
      end else if (sum_raw < -sum_lim) begin
         sum_sat = -sum_lim;
      end else begin
         sum_sat = sum_raw;
      end
      error_sum_in = sum_sat[SUM_W-1:0];

      diff = signed'({err[ERR_W-1], err}) - signed'({prev_err_ff[ERR_W-1], prev_err_ff});
   end

   ppdc_terms u_terms (
      .cfg   (cfg_ff),
      .err   (s2_err_ff),
      .sum   (s2_sum_ff),
      .diff  (s2_diff_ff),
      .drive (drive)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         error_sum_ff <= '0;
         prev_err_ff  <= '0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_load) begin
            rsp_valid_ff <= s2_valid_ff;
         end
         if (s1_move) begin
            error_sum_ff <= error_sum_in;
            prev_err_ff  <= err;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_load && req_valid) begin
         s1_setpoint_ff <= req_setpoint;
         s1_measured_ff <= req_measured;
      end
      if (s1_move) begin
         s2_err_ff  <= err;
         s2_sum_ff  <= error_sum_in;
         s2_diff_ff <= diff;
      end
      if (out_load && s2_valid_ff) begin
         rsp_drive_ff <= drive;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

endmodule

/* rtl/core/ppdc_terms.sv */
// Gain products, I-term clamp, sum and output saturation of the PID block.
// Depends on ppdc_pkg for widths and the configuration struct.
module ppdc_terms (
   input  ppdc_pkg::cfg_type                    cfg,
   input  logic signed [ppdc_pkg::ERR_W-1:0]    err,
   input  logic signed [ppdc_pkg::SUM_W-1:0]    sum,
   input  logic signed [ppdc_pkg::DIFF_W-1:0]   diff,
   output logic signed [ppdc_pkg::DATA_W-1:0]   drive
);
   import ppdc_pkg::*;

   logic signed [ERR_W+16:0]  p_prod;
   logic signed [SUM_W+16:0]  i_prod;
   logic signed [DIFF_W+16:0] d_prod;
   logic signed [ERR_W+16:0]  p_shift;
   logic signed [SUM_W+16:0]  i_shift;
   logic signed [DIFF_W+16:0] d_shift;
   logic signed [TERM_W-1:0]  p_term;
   logic signed [TERM_W-1:0]  i_raw;
   logic signed [TERM_W-1:0]  i_term;
   logic signed [TERM_W-1:0]  d_term;
   logic signed [TERM_W-1:0]  i_lim;
   logic signed [TERM_W-1:0]  o_lim;
   logic signed [TERM_W-1:0]  total;
   logic signed [TERM_W-1:0]  total_sat;

   always_comb begin
      p_prod  = signed'({1'b0, cfg.kp}) * err;
      i_prod  = signed'({1'b0, cfg.ki}) * sum;
      d_prod  = signed'({1'b0, cfg.kd}) * diff;
      p_shift = p_prod >>> 8;
      i_shift = i_prod >>> 8;
      d_shift = d_prod >>> 8;
      p_term  = p_shift[TERM_W-1:0];
      i_raw   = i_shift[TERM_W-1:0];
      d_term  = d_shift[TERM_W-1:0];

      i_lim = signed'({{(TERM_W-15){1'b0}}, cfg.i_term_max});
      if (i_raw > i_lim) begin
         i_term = i_lim;
      end else if (i_raw < -i_lim) begin
         i_term = -i_lim;
      end else begin
         i_term = i_raw;
      end

      total = p_term + i_term + d_term;
      o_lim = signed'({{(TERM_W-15){1'b0}}, cfg.output_max});
      if (total > o_lim) begin
         total_sat = o_lim;
      end else if (total < -o_lim) begin
         total_sat = -o_lim;
      end else begin
         total_sat = total;
      end
      drive = total_sat[DATA_W-1:0];
   end

endmodule

/* rtl/core/ppdc_check.sv */
// Port-level checker for the positional PID block, bound to the top level.
// Depends on ppdc_pkg for port widths.
module ppdc_check (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic signed [ppdc_pkg::DATA_W-1:0]    req_setpoint,
   input logic signed [ppdc_pkg::DATA_W-1:0]    req_measured,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [ppdc_pkg::DATA_W-1:0]    rsp_drive,
   input logic                                  csr_we,
   input logic [ppdc_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input logic [ppdc_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import ppdc_pkg::*;

   logic req_xfer;
   logic out_idle;

   assign req_xfer = req_valid && req_ready;
   assign out_idle = !csr_we || (csr_addr != REG_OUTPUT_MAX) || (csr_wdata[14:0] != 15'd0)
                   || (req_setpoint == req_measured);

   // drive never reaches the most negative code
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive != signed'({1'b1, {(DATA_W-1){1'b0}}})))
      else $error("drive outside saturation range");

   // result channel empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive))
      else $error("stalled result changed");

   // no result appears without a preceding input transfer
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !$past(rsp_valid, 1) && !$past(rsp_valid, 2) && !$past(rsp_valid, 3)
      && !$past(req_xfer, 1) && !$past(req_xfer, 2) && !$past(req_xfer, 3)
      && out_idle |-> !rsp_valid)
      else $error("result without input transfer");

endmodule

bind positional_pid_deadband_clamp ppdc_check u_ppdc_check (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_setpoint (req_setpoint),
   .req_measured (req_measured),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_drive    (rsp_drive),
   .csr_we       (csr_we),
   .csr_addr     (csr_addr),
   .csr_wdata    (csr_wdata)
);

/* verif/tb_positional_pid_deadband_clamp.sv */
// Self-checking testbench for positional_pid_deadband_clamp: directed table, then random phases
// under changing gains, limits, input idling and output stalls, scored by an in-bench predictor.
// Depends on ppdc_pkg and the block's RTL.
module tb_positional_pid_deadband_clamp;
   import ppdc_pkg::*;

   localparam int NUM_PHASES       = 8;
   localparam int PHASE_ITEMS      = 230;
   localparam int MAX_GAP          = 24;
   localparam int STUCK_LIMIT      = 2000;
   localparam int TAIL_CYCLES      = 8;
   localparam int PHASE_ALL_ONES   = 2;
   localparam int PHASE_PD_ONLY    = 5;
   localparam logic [CSR_ADDR_W-1:0] REG_UNMAPPED = 3'd7;

   typedef enum bit {ROW_WRITE, ROW_ITEM} row_kind_type;
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] data;
      logic [DATA_W-1:0]     setpoint;
      logic [DATA_W-1:0]     measured;
      bit                    typed;
      logic [DATA_W-1:0]     drive;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid    = 1'b0;
   logic                         req_ready;
   logic signed [DATA_W-1:0]     req_setpoint = '0;
   logic signed [DATA_W-1:0]     req_measured = '0;
   logic                         rsp_valid;
   logic                         rsp_ready    = 1'b0;
   logic signed [DATA_W-1:0]     rsp_drive;
   logic                         csr_we       = 1'b0;
   logic [CSR_ADDR_W-1:0]        csr_addr     = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata    = '0;

   bit                           row_typed    = 1'b0;
   logic signed [DATA_W-1:0]     row_drive    = '0;

   cfg_type gains_limits = '{kp: '0, ki: '0, kd: '0, dead_band: '0, integral_max: '0,
                             i_term_max: '0, output_max: OUTPUT_MAX_RST};
   logic signed [SUM_W-1:0]      integ_acc  = '0;
   logic signed [ERR_W-1:0]      last_error = '0;

   logic signed [DATA_W-1:0]     expected_drive[$];
   int                           items_accepted = 0;
   int                           drives_checked = 0;
   int                           csr_writes     = 0;
   int                           fail_count     = 0;
   int                           stuck_cycles   = 0;

   int                           sender_idle_pct    = 0;
   int                           receiver_stall_pct = 0;
   bit                           quiet              = 1'b1;

   positional_pid_deadband_clamp DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_setpoint (req_setpoint),
      .req_measured (req_measured),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_drive    (rsp_drive),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp_sym(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic logic signed [DATA_W-1:0] next_drive(input logic signed [DATA_W-1:0] sp,
                                                           input logic signed [DATA_W-1:0] ms);
      longint db, err, acc, pterm, iterm, dterm, total;
      db  = longint'(gains_limits.dead_band);
      err = longint'(sp) - longint'(ms);
      if (err > -db && err < db) err = 0;
      acc   = clamp_sym(longint'(integ_acc) + err, longint'(gains_limits.integral_max));
      pterm = (longint'(gains_limits.kp) * err) >>> 8;
      iterm = clamp_sym((longint'(gains_limits.ki) * acc) >>> 8,
                        longint'(gains_limits.i_term_max));
      dterm = (longint'(gains_limits.kd) * (err - longint'(last_error))) >>> 8;
      total = clamp_sym(pterm + iterm + dterm, longint'(gains_limits.output_max));
      integ_acc  = acc[SUM_W-1:0];
      last_error = err[ERR_W-1:0];
      return total[DATA_W-1:0];
   endfunction

   function automatic plan_row_type csr_row(input logic [CSR_ADDR_W-1:0] addr,
                                            input logic [CSR_DATA_W-1:0] data);
      return '{ROW_WRITE, addr, data, '0, '0, 1'b0, '0};
   endfunction

   function automatic plan_row_type item_row(input logic signed [DATA_W-1:0] sp,
                                             input logic signed [DATA_W-1:0] ms);
      return '{ROW_ITEM, '0, '0, sp, ms, 1'b0, '0};
   endfunction

   function automatic plan_row_type known_row(input logic signed [DATA_W-1:0] sp,
                                              input logic signed [DATA_W-1:0] ms,
                                              input logic signed [DATA_W-1:0] drive);
      return '{ROW_ITEM, '0, '0, sp, ms, 1'b1, drive};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] phase_reg_value(input int r, input int phase);
      logic [CSR_DATA_W-1:0] v;
      if (phase == PHASE_ALL_ONES) return '1;
      if (phase == PHASE_PD_ONLY) begin
         if (r == REG_KP || r == REG_KI || r == REG_KD) return 17'h0FFFF;
         if (r == REG_OUTPUT_MAX) return 17'h07FFF;
         return '0;
      end
      case (r)
         REG_KP, REG_KI, REG_KD: begin
            v = CSR_DATA_W'(($urandom_range(3) == 0) ? $urandom
                                                     : $urandom_range(0, 16'h0600));
         end
         REG_DEAD_BAND: begin
            v = CSR_DATA_W'(($urandom_range(2) == 0) ? 0 : $urandom_range(0, 48));
         end
         REG_INTEGRAL_MAX: begin
            v = CSR_DATA_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 4000));
         end
         REG_I_TERM_MAX: begin
            v = CSR_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(0, 32767)
                                                     : $urandom_range(0, 3000));
         end
         default: begin
            v = CSR_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(0, 32767)
                                                     : $urandom_range(8000, 32767));
         end
      endcase
      return v;
   endfunction

   always @(negedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin : scoreboard
      logic signed [DATA_W-1:0] want_drive;
      bit                       progress;
      if (reset) begin
         stuck_cycles = 0;
      end else begin
         progress = 1'b0;
         if (rsp_valid && rsp_ready) begin
            progress = 1'b1;
            drives_checked++;
            if (expected_drive.size() == 0) begin
               $display("%0t: drive transfer with none expected, expected none, got %0d",
                        $time, rsp_drive);
               fail_count++;
            end else begin
               want_drive = expected_drive.pop_front();
               if (rsp_drive !== want_drive) begin
                  $display("%0t: drive mismatch, expected %0d, got %0d",
                           $time, want_drive, rsp_drive);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            progress = 1'b1;
            items_accepted++;
            want_drive = next_drive(req_setpoint, req_measured);
            if (row_typed) want_drive = row_drive;
            expected_drive.push_back(want_drive);
         end
         stuck_cycles = progress ? 0 : stuck_cycles + 1;
      end
   end

   initial begin : watchdog
      while (stuck_cycles < STUCK_LIMIT) @(negedge clock);
      $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_item(input logic signed [DATA_W-1:0] sp,
                            input logic signed [DATA_W-1:0] ms,
                            input bit typed, input logic signed [DATA_W-1:0] drive);
      int gap;
      gap = 0;
      if (!quiet) begin
         while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_setpoint <= sp;
      req_measured <= ms;
      row_typed    <= typed;
      row_drive    <= drive;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait for the pipeline to empty
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_drive.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      csr_writes++;
      case (addr)
         REG_KP:           gains_limits.kp           = data[15:0];
         REG_KI:           gains_limits.ki           = data[15:0];
         REG_KD:           gains_limits.kd           = data[15:0];
         REG_DEAD_BAND:    gains_limits.dead_band    = data[15:0];
         REG_INTEGRAL_MAX: gains_limits.integral_max = data;
         REG_I_TERM_MAX:   gains_limits.i_term_max   = data[14:0];
         REG_OUTPUT_MAX:   gains_limits.output_max   = data[14:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      plan_row_type             plan[$];
      idle_mode_type            mode;
      int                       run_left, spread, anchor;
      bit                       tracking;
      logic signed [DATA_W-1:0] sp, ms;

      plan.push_back(known_row( 32767, -32768, 0));
      plan.push_back(known_row(-32768,  32767, 0));
      plan.push_back(csr_row(REG_KP, 17'h00100));
      plan.push_back(known_row( 32767, -32768,  32767));
      plan.push_back(known_row(-32768,  32767, -32767));
      plan.push_back(known_row(0, 0, 0));
      plan.push_back(csr_row(REG_OUTPUT_MAX, 17'h00000));
      plan.push_back(known_row(32767, -32768, 0));
      plan.push_back(csr_row(REG_OUTPUT_MAX, 17'd1000));
      plan.push_back(known_row(5000, 0, 1000));
      plan.push_back(csr_row(REG_DEAD_BAND, 17'd10));
      plan.push_back(known_row(  9,  0,   0));
      plan.push_back(known_row( 10,  0,  10));
      plan.push_back(known_row( -9,  0,   0));
      plan.push_back(known_row(  0, 10, -10));
      plan.push_back(csr_row(REG_DEAD_BAND, 17'd0));
      plan.push_back(csr_row(REG_KP, 17'h00080));
      plan.push_back(known_row(-1, 0, -1));
      plan.push_back(known_row( 1, 0,  0));
      plan.push_back(item_row( 3, 0));
      plan.push_back(csr_row(REG_KP, 17'h00000));
      plan.push_back(csr_row(REG_KI, 17'h00100));
      plan.push_back(csr_row(REG_INTEGRAL_MAX, 17'd5));
      plan.push_back(csr_row(REG_I_TERM_MAX, 17'd3));
      plan.push_back(known_row(  10, 0,  3));
      plan.push_back(known_row(-100, 0, -3));
      plan.push_back(csr_row(REG_I_TERM_MAX, 17'd0));
      plan.push_back(known_row( 100, 0,  0));
      plan.push_back(csr_row(REG_KI, 17'h1FFFF));
      plan.push_back(csr_row(REG_INTEGRAL_MAX, 17'h1FFFF));
      plan.push_back(csr_row(REG_I_TERM_MAX, 17'h1FFFF));
      plan.push_back(csr_row(REG_KD, 17'h00100));
      plan.push_back(csr_row(REG_OUTPUT_MAX, 17'h1FFFF));
      plan.push_back(csr_row(REG_UNMAPPED, 17'h1FFFF));
      plan.push_back(item_row(  1000,      0));
      plan.push_back(item_row( -1000,      0));
      plan.push_back(item_row( 32767, -32768));
      plan.push_back(item_row(-32768,  32767));
      plan.push_back(csr_row(REG_KP, 17'h0FFFF));
      plan.push_back(csr_row(REG_KD, 17'h0FFFF));
      plan.push_back(csr_row(REG_DEAD_BAND, 17'h0FFFF));
      plan.push_back(item_row( 32767, -32768));
      plan.push_back(item_row(   100,   -100));
      plan.push_back(item_row(-32768,  32767));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[n]) begin
         if (plan[n].kind == ROW_WRITE) begin
            drain_block();
            write_reg(plan[n].addr, plan[n].data);
         end else begin
            send_item(plan[n].setpoint, plan[n].measured, plan[n].typed, plan[n].drive);
         end
      end

      run_left = 0;
      tracking = 1'b0;
      spread   = 16;
      anchor   = 0;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_block();
         for (int r = REG_KP; r <= REG_OUTPUT_MAX; r++) begin
            write_reg(r[CSR_ADDR_W-1:0], phase_reg_value(r, phase));
         end
         write_reg(REG_UNMAPPED, CSR_DATA_W'($urandom));
         mode = idle_mode_type'(phase % 4);
         case (mode)
            IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
            default:       begin sender_idle_pct = 25; receiver_stall_pct = 25; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            quiet = (n % 64) < 12;
            if (run_left == 0) begin
               run_left = $urandom_range(8, 32);
               tracking = $urandom_range(9) < 7;
               anchor   = $urandom;
               case ($urandom_range(2))
                  0:       spread = 16;
                  1:       spread = 256;
                  default: spread = 4096;
               endcase
            end
            run_left--;
            if (tracking) begin
               sp = anchor[DATA_W-1:0];
               ms = DATA_W'(anchor + int'($urandom_range(0, 2 * spread)) - spread);
            end else begin
               sp = DATA_W'($urandom);
               ms = DATA_W'($urandom);
            end
            send_item(sp, ms, 1'b0, '0);
         end
         quiet = 1'b1;
      end

      drain_block();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Summary: %0d setpoint/measured transfers, %0d drive transfers compared, %0d %s",
               items_accepted, drives_checked, csr_writes, "csr writes");
      $display("Summary: directed table plus %0d random phases across idle and stall patterns",
               NUM_PHASES);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
